FILE: rtl/lcps_pkg.sv
// ----------------------------------------------------------------------------
// lcps_pkg
// Shared types and constants of the line corridor point selector.
// ----------------------------------------------------------------------------
package lcps_pkg;

  // Field widths.
  localparam int COORD_W    = 24;
  localparam int RAD_W      = 23;
  localparam int LIM_W      = 6;
  localparam int ID_W       = 16;
  localparam int DIST_W     = 48;
  localparam int RANK_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MAX_EMIT   = 32;

  // Reset values of the configuration registers.
  localparam logic [RAD_W-1:0] RADIUS_RST = 23'd6400;
  localparam logic [LIM_W-1:0] LIMIT_RST  = 6'd32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd7;

  // Accumulator selects of the arithmetic unit.
  localparam int NACC = 10;
  localparam logic [3:0] ACC_DEN = 4'd0;
  localparam logic [3:0] ACC_CX  = 4'd1;
  localparam logic [3:0] ACC_CY  = 4'd2;
  localparam logic [3:0] ACC_CZ  = 4'd3;
  localparam logic [3:0] ACC_DA  = 4'd4;
  localparam logic [3:0] ACC_DB  = 4'd5;
  localparam logic [3:0] ACC_R2  = 4'd6;
  localparam logic [3:0] ACC_NUM = 4'd7;
  localparam logic [3:0] ACC_THR = 4'd8;
  localparam logic [3:0] ACC_RCH = 4'd9;

  // Product alignment codes.
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_32 = 2'd1;
  localparam logic [1:0] SH_33 = 2'd2;
  localparam logic [1:0] SH_64 = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic [RAD_W-1:0]          radius;
  } line_cfg_t;

  typedef struct packed {
    logic              valid;
    logic              pass;
    logic [DIST_W-1:0] dist_sq;
  } arith_res_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage

FILE: rtl/lcps_arith.sv
// ----------------------------------------------------------------------------
// lcps_arith
// Corridor tests and squared line distance of one point, on one shared
// multiplier, a bit-serial square root and a bit-serial divider.
// ----------------------------------------------------------------------------
module lcps_arith (
  input  logic                             clk,
  input  logic                             rst,
  input  lcps_pkg::line_cfg_t              cfg,
  input  logic                             start,
  input  logic signed [lcps_pkg::COORD_W-1:0] pos_x,
  input  logic signed [lcps_pkg::COORD_W-1:0] pos_y,
  input  logic signed [lcps_pkg::COORD_W-1:0] pos_z,
  output lcps_pkg::arith_res_t             res
);
  import lcps_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_PA   = 12'b000000000010,
    S_WA   = 12'b000000000100,
    S_CA   = 12'b000000001000,
    S_PB   = 12'b000000010000,
    S_WB   = 12'b000000100000,
    S_CB   = 12'b000001000000,
    S_SQ   = 12'b000010000000,
    S_PC   = 12'b000100000000,
    S_WC   = 12'b001000000000,
    S_CC   = 12'b010000000000,
    S_DIV  = 12'b100000000000
  } state_t;

  state_t state;
  logic [3:0] step;
  logic       res_valid;
  logic       res_pass;

  // Coordinate differences.
  logic signed [24:0] ax, ay, az, bx, by, bz, lx, ly, lz;

  // Accumulators and the registered product.
  logic [127:0]       acc [NACC];
  logic signed [65:0] p_q;
  logic               p_vld;
  logic [3:0]         p_dst;
  logic [1:0]         p_sh;
  logic               p_sub;

  // Operand selection.
  logic signed [32:0] op_a, op_b;
  logic [3:0]         op_dst;
  logic [1:0]         op_sh;
  logic               op_sub;
  logic               op_vld;

  // Root and divider registers.
  logic [63:0] sq_x, sq_res, sq_bit;
  logic [4:0]  sq_cnt;
  logic [127:0] dv_n;
  logic [63:0]  dv_rem;
  logic [DIST_W-1:0] dv_q;
  logic [6:0]   dv_cnt;

  function automatic logic signed [32:0] s33(input logic signed [24:0] v);
    return {{8{v[24]}}, v};
  endfunction

  // Magnitudes of the cross product components and split wide operands.
  logic [51:0] cm [3];
  logic [51:0] den52;
  logic [47:0] r2_48;
  logic [27:0] reach_base;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cm[j] = acc[ACC_CX + 4'(j)][51] ? (~acc[ACC_CX + 4'(j)][51:0] + 52'd1)
                                      : acc[ACC_CX + 4'(j)][51:0];
    end
    den52      = acc[ACC_DEN][51:0];
    r2_48      = acc[ACC_R2][47:0];
    reach_base = 28'(sq_res[26:0]) + 28'(cfg.radius);
  end

  // Micro step table.
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_dst = ACC_DEN;
    op_sh  = SH_0;
    op_sub = 1'b0;
    op_vld = 1'b0;
    unique case (state)
      S_PA: begin
        op_vld = 1'b1;
        case (step)
          4'd0:  begin op_a = s33(lx); op_b = s33(lx); op_dst = ACC_DEN; end
          4'd1:  begin op_a = s33(ly); op_b = s33(ly); op_dst = ACC_DEN; end
          4'd2:  begin op_a = s33(lz); op_b = s33(lz); op_dst = ACC_DEN; end
          4'd3:  begin op_a = s33(ay); op_b = s33(bz); op_dst = ACC_CX; end
          4'd4:  begin op_a = s33(az); op_b = s33(by); op_dst = ACC_CX; op_sub = 1'b1; end
          4'd5:  begin op_a = s33(az); op_b = s33(bx); op_dst = ACC_CY; end
          4'd6:  begin op_a = s33(ax); op_b = s33(bz); op_dst = ACC_CY; op_sub = 1'b1; end
          4'd7:  begin op_a = s33(ax); op_b = s33(by); op_dst = ACC_CZ; end
          4'd8:  begin op_a = s33(ay); op_b = s33(bx); op_dst = ACC_CZ; op_sub = 1'b1; end
          4'd9:  begin op_a = s33(ax); op_b = s33(ax); op_dst = ACC_DA; end
          4'd10: begin op_a = s33(ay); op_b = s33(ay); op_dst = ACC_DA; end
          4'd11: begin op_a = s33(az); op_b = s33(az); op_dst = ACC_DA; end
          4'd12: begin op_a = s33(bx); op_b = s33(bx); op_dst = ACC_DB; end
          4'd13: begin op_a = s33(by); op_b = s33(by); op_dst = ACC_DB; end
          4'd14: begin op_a = s33(bz); op_b = s33(bz); op_dst = ACC_DB; end
          default: begin
            op_a = 33'(cfg.radius); op_b = 33'(cfg.radius); op_dst = ACC_R2;
          end
        endcase
      end
      S_PB: begin
        op_vld = 1'b1;
        op_dst = ACC_NUM;
        case (step)
          4'd0:  begin op_a = 33'(cm[0][31:0]); op_b = 33'(cm[0][31:0]); end
          4'd1:  begin op_a = 33'(cm[0][31:0]); op_b = 33'(cm[0][51:32]); op_sh = SH_33; end
          4'd2:  begin op_a = 33'(cm[0][51:32]); op_b = 33'(cm[0][51:32]); op_sh = SH_64; end
          4'd3:  begin op_a = 33'(cm[1][31:0]); op_b = 33'(cm[1][31:0]); end
          4'd4:  begin op_a = 33'(cm[1][31:0]); op_b = 33'(cm[1][51:32]); op_sh = SH_33; end
          4'd5:  begin op_a = 33'(cm[1][51:32]); op_b = 33'(cm[1][51:32]); op_sh = SH_64; end
          4'd6:  begin op_a = 33'(cm[2][31:0]); op_b = 33'(cm[2][31:0]); end
          4'd7:  begin op_a = 33'(cm[2][31:0]); op_b = 33'(cm[2][51:32]); op_sh = SH_33; end
          4'd8:  begin op_a = 33'(cm[2][51:32]); op_b = 33'(cm[2][51:32]); op_sh = SH_64; end
          4'd9:  begin
            op_a = 33'(r2_48[31:0]); op_b = 33'(den52[31:0]); op_dst = ACC_THR;
          end
          4'd10: begin
            op_a = 33'(r2_48[31:0]); op_b = 33'(den52[51:32]); op_dst = ACC_THR; op_sh = SH_32;
          end
          4'd11: begin
            op_a = 33'(r2_48[47:32]); op_b = 33'(den52[31:0]); op_dst = ACC_THR; op_sh = SH_32;
          end
          default: begin
            op_a = 33'(r2_48[47:32]); op_b = 33'(den52[51:32]); op_dst = ACC_THR;
            op_sh = SH_64;
          end
        endcase
      end
      S_PC: begin
        op_vld = 1'b1;
        op_a   = 33'(reach_base);
        op_b   = 33'(reach_base);
        op_dst = ACC_RCH;
      end
      default: begin
        op_vld = 1'b0;
      end
    endcase
  end

  // Aligned addend of the registered product.
  logic [127:0] p_ext, p_add;
  always_comb begin
    p_ext = {{62{p_q[65]}}, p_q};
    case (p_sh)
      SH_32:   p_add = p_ext << 32;
      SH_33:   p_add = p_ext << 33;
      SH_64:   p_add = p_ext << 64;
      default: p_add = p_ext;
    endcase
  end

  // Multiplier stage and accumulation.
  always_ff @(posedge clk) begin
    p_q   <= op_a * op_b;
    p_dst <= op_dst;
    p_sh  <= op_sh;
    p_sub <= op_sub;
    if (start && state == S_IDLE) begin
      for (int i = 0; i < NACC; i++) begin
        acc[i] <= '0;
      end
    end else if (p_vld) begin
      acc[p_dst] <= p_sub ? acc[p_dst] - p_add : acc[p_dst] + p_add;
    end
  end

  // Root step and divider step.
  logic [63:0] sq_trial;
  logic [63:0] dv_t;
  always_comb begin
    sq_trial = sq_res + sq_bit;
    dv_t     = {dv_rem[62:0], dv_n[127]};
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      p_vld     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      p_vld     <= op_vld;
      res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_PA;
            step  <= '0;
          end
        end
        S_PA: begin
          step <= step + 4'd1;
          if (step == 4'd15) begin
            state <= S_WA;
          end
        end
        S_WA: state <= S_CA;
        S_CA: begin
          step <= '0;
          if (acc[ACC_DEN] == '0) begin
            res_valid <= 1'b1;
            res_pass  <= 1'b0;
            state     <= S_IDLE;
          end else begin
            state <= S_PB;
          end
        end
        S_PB: begin
          step <= step + 4'd1;
          if (step == 4'd12) begin
            state <= S_WB;
          end
        end
        S_WB: state <= S_CB;
        S_CB: begin
          sq_x   <= acc[ACC_DEN][63:0];
          sq_res <= '0;
          sq_bit <= 64'd1 << 62;
          sq_cnt <= '0;
          if (acc[ACC_NUM] < acc[ACC_THR]) begin
            state <= S_SQ;
          end else begin
            res_valid <= 1'b1;
            res_pass  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_SQ: begin
          if (sq_x >= sq_trial) begin
            sq_x   <= sq_x - sq_trial;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 5'd1;
          if (sq_cnt == 5'd31) begin
            state <= S_PC;
          end
        end
        S_PC: state <= S_WC;
        S_WC: state <= S_CC;
        S_CC: begin
          dv_n   <= acc[ACC_NUM];
          dv_rem <= '0;
          dv_q   <= '0;
          dv_cnt <= '0;
          if ((acc[ACC_DA][63:0] < acc[ACC_RCH][63:0]) &&
              (acc[ACC_DB][63:0] < acc[ACC_RCH][63:0])) begin
            state <= S_DIV;
          end else begin
            res_valid <= 1'b1;
            res_pass  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_DIV: begin
          dv_n <= dv_n << 1;
          if (dv_t >= acc[ACC_DEN][63:0]) begin
            dv_rem <= dv_t - acc[ACC_DEN][63:0];
            dv_q   <= {dv_q[DIST_W-2:0], 1'b1};
          end else begin
            dv_rem <= dv_t;
            dv_q   <= {dv_q[DIST_W-2:0], 1'b0};
          end
          dv_cnt <= dv_cnt + 7'd1;
          if (dv_cnt == 7'd127) begin
            res_valid <= 1'b1;
            res_pass  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Differences are taken as the item arrives.
  always_ff @(posedge clk) begin
    if (start && state == S_IDLE) begin
      ax <= 25'(pos_x) - 25'(cfg.start_x);
      ay <= 25'(pos_y) - 25'(cfg.start_y);
      az <= 25'(pos_z) - 25'(cfg.start_z);
      bx <= 25'(pos_x) - 25'(cfg.end_x);
      by <= 25'(pos_y) - 25'(cfg.end_y);
      bz <= 25'(pos_z) - 25'(cfg.end_z);
      lx <= 25'(cfg.end_x) - 25'(cfg.start_x);
      ly <= 25'(cfg.end_y) - 25'(cfg.start_y);
      lz <= 25'(cfg.end_z) - 25'(cfg.start_z);
    end
  end

  assign res = '{valid: res_valid, pass: res_pass, dist_sq: dv_q};

endmodule

FILE: rtl/lcps_cell.sv
// ----------------------------------------------------------------------------
// lcps_cell
// One place of the sorted list: holds an id and a distance, takes part in
// an insertion and shifts toward the head while the list is sent out.
// ----------------------------------------------------------------------------
module lcps_cell (
  input  logic                          clk,
  input  lcps_pkg::cell_ctl_t           ctl,
  input  logic                          valid,
  input  logic [lcps_pkg::ID_W-1:0]     new_id,
  input  logic [lcps_pkg::DIST_W-1:0]   new_dist,
  input  logic                          prev_keep,
  input  logic [lcps_pkg::ID_W-1:0]     prev_id,
  input  logic [lcps_pkg::DIST_W-1:0]   prev_dist,
  input  logic [lcps_pkg::ID_W-1:0]     next_id,
  input  logic [lcps_pkg::DIST_W-1:0]   next_dist,
  output logic                          keep,
  output logic [lcps_pkg::ID_W-1:0]     id,
  output logic [lcps_pkg::DIST_W-1:0]   dist_q
);
  import lcps_pkg::*;

  // An entry at or below the new distance stays; ties keep arrival order.
  assign keep = valid && (dist_q <= new_dist);

  always_ff @(posedge clk) begin
    if (ctl.ins && !keep) begin
      if (prev_keep) begin
        id     <= new_id;
        dist_q <= new_dist;
      end else begin
        id     <= prev_id;
        dist_q <= prev_dist;
      end
    end else if (ctl.pop) begin
      id     <= next_id;
      dist_q <= next_dist;
    end
  end

endmodule

FILE: rtl/line_corridor_point_select_core.sv
// ----------------------------------------------------------------------------
// line_corridor_point_select_core
// Keeps the points nearest to a configured line segment, sorted by distance.
// ----------------------------------------------------------------------------
// Points arrive on the input channel (in_valid, in_stall). Each is tested
// against the corridor around the line and, if it passes, goes into a chain
// of list cells sorted by squared line distance. After the point marked
// final_point the list is sent out on the output channel (out_valid,
// out_stall), one transfer per kept point, nearest first, the last with
// run_end; an empty list gives one transfer with none_kept set.
// One point at a time is processed through a shared 33x33 multiplier, a
// bit-serial square root and a bit-serial divider; a new point is taken
// only once the last one is through (in_stall), and a zero-length line
// passes no point. The list is then sent out at one transfer per cycle
// while out_stall is low; a stalled result is held in the output register.
// Reset empties the list and restores the register defaults. Configuration
// is written through cfg_wr_en, cfg_index and cfg_wdata; the user must do
// so only while no point is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
module line_corridor_point_select_core #(
  parameter int LIST_DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [lcps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lcps_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [lcps_pkg::COORD_W-1:0]   pos_x,
  input  logic signed [lcps_pkg::COORD_W-1:0]   pos_y,
  input  logic signed [lcps_pkg::COORD_W-1:0]   pos_z,
  input  logic [lcps_pkg::ID_W-1:0]             point_id,
  input  logic                                  final_point,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [lcps_pkg::ID_W-1:0]             kept_id,
  output logic [lcps_pkg::DIST_W-1:0]           line_dist_sq,
  output logic [lcps_pkg::RANK_W-1:0]           rank,
  output logic                                  none_kept,
  output logic                                  run_end
);
  import lcps_pkg::*;

  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int IW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CAP = (LIST_DEPTH < MAX_EMIT) ? LIST_DEPTH : MAX_EMIT;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_WORK = 4'b0010,
    T_FIN  = 4'b0100,
    T_EMIT = 4'b1000
  } tstate_t;

  tstate_t          state;
  line_cfg_t        cfg;
  logic [LIM_W-1:0] keep_limit;
  arith_res_t       ares;
  logic [ID_W-1:0]  cur_id;
  logic             cur_final;
  logic [CW-1:0]    count;
  logic [CW-1:0]    em_n, em_idx;
  logic [RANK_W-1:0] em_rank;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_x <= '0;
      cfg.start_y <= '0;
      cfg.start_z <= '0;
      cfg.end_x   <= '0;
      cfg.end_y   <= '0;
      cfg.end_z   <= '0;
      cfg.radius  <= RADIUS_RST;
      keep_limit  <= LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_START_X: cfg.start_x <= cfg_wdata;
        REG_START_Y: cfg.start_y <= cfg_wdata;
        REG_START_Z: cfg.start_z <= cfg_wdata;
        REG_END_X:   cfg.end_x   <= cfg_wdata;
        REG_END_Y:   cfg.end_y   <= cfg_wdata;
        REG_END_Z:   cfg.end_z   <= cfg_wdata;
        REG_RADIUS:  cfg.radius  <= cfg_wdata[RAD_W-1:0];
        REG_LIMIT:   keep_limit  <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective limit and current list length.
  logic [LIM_W-1:0] klim;
  logic [CW-1:0]    lim, n_cur;
  logic [IW-1:0]    lim_m1;
  always_comb begin
    klim   = (keep_limit == '0) ? LIM_W'(1) : keep_limit;
    lim    = (klim > LIM_W'(CAP)) ? CW'(CAP) : CW'(klim);
    n_cur  = (count < lim) ? count : lim;
    lim_m1 = IW'(lim - CW'(1));
  end

  // Input transfer.
  logic in_acc;
  assign in_stall = (state != T_IDLE);
  assign in_acc   = in_valid && !in_stall;

  lcps_arith u_arith (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .start (in_acc),
    .pos_x (pos_x),
    .pos_y (pos_y),
    .pos_z (pos_z),
    .res   (ares)
  );

  // Cell chain.
  logic [ID_W-1:0]       c_id   [LIST_DEPTH];
  logic [DIST_W-1:0]     c_dist [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] c_keep, c_valid;
  cell_ctl_t             ctl;
  logic                  drop, emit_load;

  assign drop = (n_cur == lim) && c_keep[lim_m1];

  always_comb begin
    ctl.ins = (state == T_WORK) && ares.valid && ares.pass && !drop;
    ctl.pop = emit_load && (em_n != '0);
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic              pk;
    logic [ID_W-1:0]   pid, nid;
    logic [DIST_W-1:0] pdist, ndist;
    assign c_valid[i] = (CW'(i) < n_cur);
    if (i == 0) begin : g_head
      assign pk    = 1'b1;
      assign pid   = cur_id;
      assign pdist = ares.dist_sq;
    end else begin : g_body
      assign pk    = c_keep[i-1];
      assign pid   = c_id[i-1];
      assign pdist = c_dist[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_tail
      assign nid   = c_id[i];
      assign ndist = c_dist[i];
    end else begin : g_mid
      assign nid   = c_id[i+1];
      assign ndist = c_dist[i+1];
    end
    lcps_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid     (c_valid[i]),
      .new_id    (cur_id),
      .new_dist  (ares.dist_sq),
      .prev_keep (pk),
      .prev_id   (pid),
      .prev_dist (pdist),
      .next_id   (nid),
      .next_dist (ndist),
      .keep      (c_keep[i]),
      .id        (c_id[i]),
      .dist_q    (c_dist[i])
    );
  end

  assign emit_load = (state == T_EMIT) && (!out_valid || !out_stall);

  // Control sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (in_acc) begin
            state <= T_WORK;
          end
        end
        T_WORK: begin
          if (ares.valid) begin
            if (ares.pass) begin
              count <= (!drop && (n_cur < lim)) ? n_cur + CW'(1) : n_cur;
            end
            state <= cur_final ? T_FIN : T_IDLE;
          end
        end
        T_FIN: begin
          em_n    <= n_cur;
          em_idx  <= '0;
          em_rank <= '0;
          count   <= '0;
          state   <= T_EMIT;
        end
        T_EMIT: begin
          if (emit_load) begin
            em_idx  <= em_idx + CW'(1);
            em_rank <= em_rank + RANK_W'(1);
            if (em_n == '0 || em_idx == em_n - CW'(1)) begin
              state <= T_IDLE;
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // Item bookkeeping.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_id    <= point_id;
      cur_final <= final_point;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      if (em_n == '0) begin
        kept_id      <= '0;
        line_dist_sq <= '0;
        rank         <= '0;
        none_kept    <= 1'b1;
        run_end      <= 1'b1;
      end else begin
        kept_id      <= c_id[0];
        line_dist_sq <= c_dist[0];
        rank         <= em_rank;
        none_kept    <= 1'b0;
        run_end      <= (em_idx == em_n - CW'(1));
      end
    end
  end

endmodule
